@@ src/assert_macros.svh @@
// Assertion macros used by the top-level RTL file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define GSR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("gsr: same-cycle check failed");

// next-cycle implication
`define GSR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("gsr: next-cycle check failed");

`endif

@@ src/gsr_pkg.sv @@
// Types and constants of the Gaussian spot renderer
`timescale 1ns / 1ps
`default_nettype none
package gsr_pkg;

    localparam int GRID_SIZE_DEF       = 1024;
    localparam int EXP_TABLE_DEPTH_DEF = 256;

    localparam int CFG_AW = 3;
    localparam int CFG_DW = 24;

    localparam logic [15:0] WIDTH_RESET = 16'd640;

    localparam logic [63:0] LN2_Q32   = 64'd2977044472;
    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;

    localparam int DIVW = 47;
    localparam logic [DIVW-1:0] COEF_NUM = DIVW'(LN2_Q32 << 14);

    typedef enum logic [CFG_AW-1:0] {
        REG_CENTER_X    = 3'd0,
        REG_CENTER_Y    = 3'd1,
        REG_PEAK_WIDTH  = 3'd2,
        REG_BASELINE    = 3'd3,
        REG_PEAK_HEIGHT = 3'd4
    } cfg_reg_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_SQUARE,
        DIV_RUN
    } div_state_t;

    typedef struct packed {
        logic        over;
        logic [6:0]  shift;
        logic [15:0] frac;
    } arg_t;

    typedef struct packed {
        logic        over;
        logic [30:0] e;
    } exp_t;

endpackage
`default_nettype wire

@@ src/gsr_coef_div.sv @@
// Falloff coefficient unit: squared width and restoring divide, one bit per cycle
`timescale 1ns / 1ps
`default_nettype none
module gsr_coef_div
    import gsr_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [15:0] width,
    output logic [31:0]      coef,
    output logic             busy
);

    localparam int CW = $clog2(DIVW);

    div_state_t      state_reg, state_next;
    logic [31:0]     w2_reg, w2_next;
    logic [DIVW-1:0] dd_reg, dd_next;
    logic [31:0]     rem_reg, rem_next;
    logic [DIVW-1:0] quo_reg, quo_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [31:0]     coef_reg, coef_next;

    logic [31:0] sq;
    logic [32:0] rem_sh;
    logic        qbit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DIV_SQUARE;
            coef_reg  <= '0;
        end else begin
            state_reg <= state_next;
            coef_reg  <= coef_next;
        end
    end

    always_ff @(posedge aclk) begin
        w2_reg  <= w2_next;
        dd_reg  <= dd_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        cnt_reg <= cnt_next;
    end

    always_comb begin
        state_next = state_reg;
        w2_next    = w2_reg;
        dd_next    = dd_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        cnt_next   = cnt_reg;
        coef_next  = coef_reg;
        sq         = 32'(width) * 32'(width);
        rem_sh     = {rem_reg, dd_reg[DIVW-1]};
        qbit       = (rem_sh >= {1'b0, w2_reg});
        case (state_reg)
            DIV_IDLE: begin
            end
            DIV_SQUARE: begin
                w2_next    = sq;
                dd_next    = COEF_NUM + DIVW'(sq >> 1);
                rem_next   = '0;
                quo_next   = '0;
                cnt_next   = CW'(DIVW - 1);
                state_next = DIV_RUN;
            end
            DIV_RUN: begin
                dd_next  = {dd_reg[DIVW-2:0], 1'b0};
                rem_next = qbit ? 32'(rem_sh - {1'b0, w2_reg}) : rem_sh[31:0];
                quo_next = {quo_reg[DIVW-2:0], qbit};
                if (cnt_reg == '0) begin
                    if (w2_reg == '0 || quo_next[DIVW-1:32] != '0) begin
                        coef_next = '1;
                    end else begin
                        coef_next = quo_next[31:0];
                    end
                    state_next = DIV_IDLE;
                end else begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            default: begin
                state_next = DIV_IDLE;
            end
        endcase
        if (start) begin
            state_next = DIV_SQUARE;
        end
    end

    assign coef = coef_reg;
    assign busy = (state_reg != DIV_IDLE);

endmodule
`default_nettype wire

@@ src/gsr_arg.sv @@
// Distance and exponent argument pipeline: offsets, squares, scaling, base-2 split
`timescale 1ns / 1ps
`default_nettype none
module gsr_arg
    import gsr_pkg::*;
#(
    parameter int GRID_SIZE = GRID_SIZE_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [9:0]  col,
    input  wire logic [9:0]  row,
    input  wire logic [15:0] center_x,
    input  wire logic [15:0] center_y,
    input  wire logic [31:0] coef,
    output logic             out_valid,
    input  wire logic        out_ready,
    output arg_t             arg
);

    localparam int NS = 6;
    localparam logic [16:0] LAST = 17'(GRID_SIZE - 1);

    logic [NS-1:0] v_reg, v_next;
    logic [NS:0]   en;

    logic [9:0]  colc, rowc;
    logic [15:0] px, py;
    logic [15:0] dx_reg, dy_reg;
    logic [31:0] sqx_reg, sqy_reg;
    logic [32:0] d2;
    logic [48:0] plo_reg, phi_reg;
    logic [64:0] prod;
    logic        over4_reg, over5_reg;
    logic [20:0] a_reg;
    logic [51:0] tm_reg;
    logic [52:0] tsum;
    logic [22:0] t;
    arg_t        arg_reg;

    always_comb begin
        en[NS] = out_ready;
        for (int i = NS - 1; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
        v_next[0] = en[0] ? in_valid : v_reg[0];
        for (int i = 1; i < NS; i++) begin
            v_next[i] = en[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    always_comb begin
        colc = ({7'b0, col} > LAST) ? LAST[9:0] : col;
        rowc = ({7'b0, row} > LAST) ? LAST[9:0] : row;
        px   = {colc, 6'b0};
        py   = {rowc, 6'b0};
        d2   = 33'(sqx_reg) + 33'(sqy_reg);
        prod = 65'(plo_reg) + (65'(phi_reg) << 16);
        tsum = 53'(tm_reg) + (53'd1 << 29);
        t    = tsum[52:30];
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            dx_reg <= (px >= center_x) ? px - center_x : center_x - px;
            dy_reg <= (py >= center_y) ? py - center_y : center_y - py;
        end
        if (en[1]) begin
            sqx_reg <= 32'(dx_reg) * 32'(dx_reg);
            sqy_reg <= 32'(dy_reg) * 32'(dy_reg);
        end
        if (en[2]) begin
            plo_reg <= 49'(d2) * 49'(coef[15:0]);
            phi_reg <= 49'(d2) * 49'(coef[31:16]);
        end
        if (en[3]) begin
            over4_reg <= (prod > (65'd1 << 48));
            a_reg     <= prod[48:28];
        end
        if (en[4]) begin
            over5_reg <= over4_reg;
            tm_reg    <= 52'(a_reg) * 52'(LOG2E_Q30);
        end
        if (en[5]) begin
            arg_reg.over  <= over5_reg;
            arg_reg.shift <= t[22:16];
            arg_reg.frac  <= t[15:0];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];
    assign arg       = arg_reg;

endmodule
`default_nettype wire

@@ src/gsr_exp.sv @@
// Power-of-two pipeline: table lookup, linear interpolation, integer shift
`timescale 1ns / 1ps
`default_nettype none
module gsr_exp
    import gsr_pkg::*;
#(
    parameter int EXP_TABLE_DEPTH = EXP_TABLE_DEPTH_DEF
) (
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic in_valid,
    output logic      in_ready,
    input  wire arg_t arg,
    output logic      out_valid,
    input  wire logic out_ready,
    output exp_t      res
);

    localparam int NS = 4;
    localparam int TW = $clog2(EXP_TABLE_DEPTH + 1);
    localparam int PW = 16 + TW;

    typedef logic [30:0] tab_t [0:EXP_TABLE_DEPTH];

    function automatic tab_t build_tab();
        tab_t        tb;
        logic [63:0] x;
        logic [63:0] sum;
        logic [63:0] term;
        for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
            x    = (LN2_Q32 * 64'(k)) / EXP_TABLE_DEPTH;
            sum  = 64'd1 << 32;
            term = 64'd1 << 32;
            for (int n = 1; n < 24; n++) begin
                if (term != '0) begin
                    term = ((term * x) >> 32) / 64'(n);
                    if (n[0]) begin
                        sum = sum - term;
                    end else begin
                        sum = sum + term;
                    end
                end
            end
            tb[k] = 31'((sum + 64'd2) >> 2);
        end
        return tb;
    endfunction

    localparam tab_t POW_TAB = build_tab();

    logic [NS-1:0] v_reg, v_next;
    logic [NS:0]   en;

    logic [PW-1:0] pos_reg;
    logic [6:0]    sh1_reg, sh2_reg, sh3_reg;
    logic          ov1_reg, ov2_reg, ov3_reg;
    logic [TW-1:0] idx, idx1;
    logic [30:0]   hi_reg, lo_reg, hi3_reg;
    logic [15:0]   fr_reg;
    logic [46:0]   dm_reg;
    logic [30:0]   v;
    exp_t          res_reg;

    always_comb begin
        en[NS] = out_ready;
        for (int i = NS - 1; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
        v_next[0] = en[0] ? in_valid : v_reg[0];
        for (int i = 1; i < NS; i++) begin
            v_next[i] = en[i] ? v_reg[i-1] : v_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    always_comb begin
        idx  = pos_reg[16 +: TW];
        idx1 = idx + 1'b1;
        v    = hi3_reg - dm_reg[46:16];
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            pos_reg <= PW'(arg.frac) * PW'(EXP_TABLE_DEPTH);
            sh1_reg <= arg.shift;
            ov1_reg <= arg.over;
        end
        if (en[1]) begin
            hi_reg  <= POW_TAB[idx];
            lo_reg  <= POW_TAB[idx1];
            fr_reg  <= pos_reg[15:0];
            sh2_reg <= sh1_reg;
            ov2_reg <= ov1_reg;
        end
        if (en[2]) begin
            dm_reg  <= 47'(hi_reg - lo_reg) * 47'(fr_reg);
            hi3_reg <= hi_reg;
            sh3_reg <= sh2_reg;
            ov3_reg <= ov2_reg;
        end
        if (en[3]) begin
            res_reg.e    <= v >> sh3_reg;
            res_reg.over <= ov3_reg;
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[NS-1];
    assign res       = res_reg;

endmodule
`default_nettype wire

@@ src/gaussian_spot_render_unit.sv @@
// Gaussian spot renderer top level: configuration, output scaling and saturation
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
// Returns baseline + (peak_height - baseline) * exp(-4 ln2 * d^2 / peak_width^2) for one
// pixel per clock while the divider is idle and m_ready is high. The path has six argument
// stages, four exponential stages and two scaling stages. A peak_width write, and reset,
// start the coefficient divider, which retires one quotient bit per cycle; s_ready stays low
// while it runs. Saturated results set m_clipped.
module gaussian_spot_render_unit
    import gsr_pkg::*;
#(
    parameter int GRID_SIZE       = GRID_SIZE_DEF,
    parameter int EXP_TABLE_DEPTH = EXP_TABLE_DEPTH_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cfg_we,
    input  wire logic [CFG_AW-1:0] cfg_addr,
    input  wire logic [CFG_DW-1:0] cfg_wdata,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire logic [9:0]        s_col,
    input  wire logic [9:0]        s_row,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output logic signed [23:0]     m_pixel_value,
    output logic                   m_clipped
);

    localparam int NS = 2;

    logic [15:0]        center_x_reg, center_y_reg, peak_width_reg;
    logic signed [23:0] baseline_reg, peak_height_reg;

    logic        div_start, div_busy;
    logic [31:0] coef;

    logic arg_in_ready, arg_valid, arg_ready;
    arg_t arg;
    logic exp_valid;
    exp_t expv;

    logic [NS-1:0] v_reg, v_next;
    logic [NS:0]   en;

    logic signed [24:0] scale;
    logic [24:0]        mag;
    logic [55:0]        pm_reg;
    logic               neg_reg, ov_reg;
    logic signed [23:0] base_reg;
    logic [56:0]        rnd;
    logic [26:0]        term;
    logic signed [27:0] sum;
    logic signed [23:0] pix_reg;
    logic               clip_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            center_x_reg    <= '0;
            center_y_reg    <= '0;
            peak_width_reg  <= WIDTH_RESET;
            baseline_reg    <= '0;
            peak_height_reg <= '0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_CENTER_X:    center_x_reg    <= cfg_wdata[15:0];
                REG_CENTER_Y:    center_y_reg    <= cfg_wdata[15:0];
                REG_PEAK_WIDTH:  peak_width_reg  <= cfg_wdata[15:0];
                REG_BASELINE:    baseline_reg    <= cfg_wdata;
                REG_PEAK_HEIGHT: peak_height_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign div_start = cfg_we && (cfg_addr == REG_PEAK_WIDTH);

    gsr_coef_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .width   (peak_width_reg),
        .coef    (coef),
        .busy    (div_busy)
    );

    gsr_arg #(
        .GRID_SIZE (GRID_SIZE)
    ) u_arg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid && !div_busy),
        .in_ready  (arg_in_ready),
        .col       (s_col),
        .row       (s_row),
        .center_x  (center_x_reg),
        .center_y  (center_y_reg),
        .coef      (coef),
        .out_valid (arg_valid),
        .out_ready (arg_ready),
        .arg       (arg)
    );

    gsr_exp #(
        .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
    ) u_exp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (arg_valid),
        .in_ready  (arg_ready),
        .arg       (arg),
        .out_valid (exp_valid),
        .out_ready (en[0]),
        .res       (expv)
    );

    assign s_ready = arg_in_ready && !div_busy;

    always_comb begin
        en[NS] = m_ready;
        for (int i = NS - 1; i >= 0; i--) begin
            en[i] = !v_reg[i] || en[i+1];
        end
        v_next[0] = en[0] ? exp_valid : v_reg[0];
        v_next[1] = en[1] ? v_reg[0] : v_reg[1];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else begin
            v_reg <= v_next;
        end
    end

    always_comb begin
        scale = 25'(peak_height_reg) - 25'(baseline_reg);
        mag   = scale[24] ? 25'(-scale) : scale;
        rnd   = 57'(pm_reg) + (57'd1 << 29);
        term  = rnd[56:30];
        if (ov_reg) begin
            sum = 28'(base_reg);
        end else if (neg_reg) begin
            sum = 28'(base_reg) - $signed({1'b0, term});
        end else begin
            sum = 28'(base_reg) + $signed({1'b0, term});
        end
    end

    always_ff @(posedge aclk) begin
        if (en[0]) begin
            pm_reg   <= 56'(mag) * 56'(expv.e);
            neg_reg  <= scale[24];
            ov_reg   <= expv.over;
            base_reg <= baseline_reg;
        end
        if (en[1]) begin
            if (sum > 28'sd8388607) begin
                pix_reg  <= 24'sh7FFFFF;
                clip_reg <= 1'b1;
            end else if (sum < -28'sd8388608) begin
                pix_reg  <= 24'sh800000;
                clip_reg <= 1'b1;
            end else begin
                pix_reg  <= sum[23:0];
                clip_reg <= 1'b0;
            end
        end
    end

    assign m_valid       = v_reg[1];
    assign m_pixel_value = pix_reg;
    assign m_clipped     = clip_reg;

    `GSR_ASSERT_IMP(a_busy_blocks_input, div_busy, !s_ready)
    `GSR_ASSERT_NXT(a_width_write_busy, cfg_we && cfg_addr == REG_PEAK_WIDTH, div_busy)
    `GSR_ASSERT_IMP(a_clip_at_limit, m_valid && m_clipped,
                    m_pixel_value == 24'sh7FFFFF || m_pixel_value == 24'sh800000)

endmodule
`default_nettype wire
